// File: rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared constants for the stepper trapezoid ramp
// Default widths, phase codes, action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int STEP_BITS_DEF     = 24;
  localparam int PERIOD_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int REM_BITS   = 32;
  localparam int PHASE_BITS = 3;

  localparam logic [PHASE_BITS-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_ACCEL = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_RUN   = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_DECEL = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_STOP  = 3'd4;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_STEPS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PERIOD   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PERIOD   = 2'd3;

  localparam int FIRST_PERIOD_RST = 50000;
  localparam int MIN_PERIOD_RST   = 20;
  localparam int MAX_PERIOD_RST   = 50000;

endpackage

// File: rtl/stp_if.sv
// ----------------------------------------------------------------------------
// stp_if: command and result channels
// Valid/ready channels carrying one command item and one result item.
// ----------------------------------------------------------------------------
interface stp_in_if import stp_pkg::*; #(
  parameter int STEP_BITS = STEP_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [STEP_BITS-1:0] move_steps;
  logic                 count_up;

  modport source (output valid, output action, output move_steps, output count_up,
                  input ready);
  modport sink (input valid, input action, input move_steps, input count_up,
                output ready);
endinterface

interface stp_out_if import stp_pkg::*; #(
  parameter int PERIOD_BITS   = PERIOD_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [PERIOD_BITS-1:0]          step_period;
  logic signed [POSITION_BITS-1:0] position;
  logic [PHASE_BITS-1:0]           phase;
  logic                            move_accepted;
  logic                            move_done;

  modport source (output valid, output step_period, output position, output phase,
                  output move_accepted, output move_done, input ready);
  modport sink (input valid, input step_period, input position, input phase,
                input move_accepted, input move_done, output ready);
endinterface

// File: rtl/stp_div.sv
// ----------------------------------------------------------------------------
// stp_div: bit-serial restoring divider
// Shifts the numerator through one bit per cycle and returns quotient and
// remainder.
// ----------------------------------------------------------------------------
module stp_div import stp_pkg::*; #(
  parameter int NUM_BITS = 33,
  parameter int DEN_BITS = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic                done,
  output logic [NUM_BITS-1:0] quot,
  output logic [DEN_BITS-1:0] rem
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0] num_r, num_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  assign trial = {rem_r, num_r[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(NUM_BITS);
      num_nxt  = numer;
      den_nxt  = denom;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      num_nxt = {num_r[NUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

// File: rtl/stepper_trapezoid_ramp.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp: trapezoid and triangle step ramp planner
// A start item plans a move (zero steps stop it); a tick item during a move
// steps the position, advances the phase and, while ramping, computes the
// next step period with a carried remainder. Every item accepted on in_ch
// gives exactly one result item on out_ch. Start items and run, stop and
// idle ticks need no divide: with the output register free, the result is
// registered at the accepting edge. Accelerating and decelerating ticks
// divide 2p + r by 4c +/- 1 in a bit-serial divider that retires one
// quotient bit per cycle; such an item passes through S_LOAD and S_DIV.
// The command side takes a new item only when no item is in progress; a
// result waiting in the output register does not block that.
// If the receiver stalls, the result holds on out_ch and a newer finished
// result waits inside until the register frees.
// cfg_we writes register cfg_idx from cfg_data at once; write only when idle.
// Synchronous reset clears the motion state, the position, the result valid
// flag and the registers to their documented defaults.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp import stp_pkg::*; #(
  parameter int STEP_BITS     = STEP_BITS_DEF,
  parameter int PERIOD_BITS   = PERIOD_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  stp_in_if.sink                  in_ch,
  stp_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [((PERIOD_BITS > STEP_BITS) ? PERIOD_BITS : STEP_BITS)-1:0] cfg_data
);

  localparam int NUM_W = ((PERIOD_BITS + 1 > REM_BITS) ? PERIOD_BITS + 1 : REM_BITS) + 1;
  localparam int DEN_W = STEP_BITS + 2;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_WAIT} state_t;

  state_t                   state_r, state_nxt;
  logic [PERIOD_BITS-1:0]   first_r, first_nxt;
  logic [STEP_BITS-1:0]     ramp_r, ramp_nxt;
  logic [PERIOD_BITS-1:0]   min_r, min_nxt;
  logic [PERIOD_BITS-1:0]   max_r, max_nxt;
  logic [PERIOD_BITS-1:0]   period_r, period_nxt;
  logic [REM_BITS-1:0]      rem_r, rem_nxt;
  logic [STEP_BITS-1:0]     count_r, count_nxt;
  logic [STEP_BITS-1:0]     limit_r, limit_nxt;
  logic [STEP_BITS-1:0]     run_r, run_nxt;
  logic [STEP_BITS-1:0]     decel_r, decel_nxt;
  logic [PHASE_BITS-1:0]    phase_r, phase_nxt;
  logic                     tri_r, tri_nxt;
  logic                     up_r, up_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     acc_r, acc_nxt;
  logic                     done_r, done_nxt;
  logic                     ov_r, ov_nxt;
  logic [PERIOD_BITS-1:0]   op_r, op_nxt;
  logic [POSITION_BITS-1:0] opos_r, opos_nxt;
  logic [PHASE_BITS-1:0]    oph_r, oph_nxt;
  logic                     oacc_r, oacc_nxt;
  logic                     odone_r, odone_nxt;

  logic                     in_fire;
  logic                     out_free;
  logic                     finish;
  logic                     div_start;
  logic                     div_done;
  logic [NUM_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [NUM_W-1:0]         div_quot;
  logic [DEN_W-1:0]         div_rem;
  logic [STEP_BITS-1:0]     half_steps;
  logic [PERIOD_BITS-1:0]   p_first;
  logic [PERIOD_BITS-1:0]   p_acc_raw;
  logic [PERIOD_BITS-1:0]   p_acc;
  logic [NUM_W:0]           p_sum;
  logic [PERIOD_BITS-1:0]   p_dec;
  logic [STEP_BITS-1:0]     run_less;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;

  assign div_num = NUM_W'({period_r, 1'b0}) + NUM_W'(rem_r);
  assign div_den = (phase_r == PH_ACCEL) ? {count_r, 2'b01}
                                         : {count_r, 2'b00} - DEN_W'(1);

  stp_div #(
    .NUM_BITS(NUM_W),
    .DEN_BITS(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .numer(div_num),
    .denom(div_den),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign half_steps = in_ch.move_steps >> 1;
  assign p_first    = (first_r <= min_r) ? min_r : ((first_r >= max_r) ? max_r : first_r);
  assign p_acc_raw  = (div_quot >= NUM_W'(period_r)) ? '0
                                                     : period_r - div_quot[PERIOD_BITS-1:0];
  assign p_acc      = (p_acc_raw <= min_r) ? min_r : p_acc_raw;
  assign p_sum      = (NUM_W + 1)'(period_r) + (NUM_W + 1)'(div_quot);
  assign p_dec      = (p_sum >= (NUM_W + 1)'(max_r)) ? max_r : p_sum[PERIOD_BITS-1:0];
  assign run_less   = run_r - STEP_BITS'(1);

  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    ramp_nxt   = ramp_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    period_nxt = period_r;
    rem_nxt    = rem_r;
    count_nxt  = count_r;
    limit_nxt  = limit_r;
    run_nxt    = run_r;
    decel_nxt  = decel_r;
    phase_nxt  = phase_r;
    tri_nxt    = tri_r;
    up_nxt     = up_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    done_nxt   = done_r;
    ov_nxt     = ov_r && !out_ch.ready;
    op_nxt     = op_r;
    opos_nxt   = opos_r;
    oph_nxt    = oph_r;
    oacc_nxt   = oacc_r;
    odone_nxt  = odone_r;
    finish     = 1'b0;
    div_start  = 1'b0;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_FIRST_PERIOD: first_nxt = cfg_data[PERIOD_BITS-1:0];
        CFG_RAMP_STEPS:   ramp_nxt  = cfg_data[STEP_BITS-1:0];
        CFG_MIN_PERIOD:   min_nxt   = cfg_data[PERIOD_BITS-1:0];
        CFG_MAX_PERIOD:   max_nxt   = cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acc_nxt  = 1'b0;
          done_nxt = 1'b0;
          finish   = 1'b1;
          if (in_ch.action == ACT_START) begin
            if (in_ch.move_steps == '0) begin
              phase_nxt  = PH_IDLE;
              period_nxt = '0;
              rem_nxt    = '0;
              count_nxt  = '0;
            end else if (phase_r == PH_IDLE && ramp_r != '0) begin
              period_nxt = p_first;
              rem_nxt    = '0;
              count_nxt  = '0;
              up_nxt     = in_ch.count_up;
              if (ramp_r < half_steps) begin
                tri_nxt   = 1'b0;
                run_nxt   = in_ch.move_steps - (ramp_r << 1);
                decel_nxt = ramp_r;
                limit_nxt = ramp_r;
              end else begin
                tri_nxt   = 1'b1;
                limit_nxt = half_steps + STEP_BITS'(in_ch.move_steps[0]);
                run_nxt   = half_steps;
              end
              phase_nxt = PH_ACCEL;
              acc_nxt   = 1'b1;
            end
          end else if (phase_r != PH_IDLE) begin
            pos_nxt = up_r ? pos_r + POSITION_BITS'(1) : pos_r - POSITION_BITS'(1);
            case (phase_r)
              PH_ACCEL: begin
                count_nxt = count_r + STEP_BITS'(1);
                finish    = 1'b0;
                state_nxt = S_LOAD;
              end
              PH_RUN: begin
                count_nxt = count_r + STEP_BITS'(1);
                if (count_r + STEP_BITS'(1) >= limit_r) begin
                  phase_nxt = (decel_r == '0) ? PH_STOP : PH_DECEL;
                  count_nxt = decel_r;
                end
              end
              PH_DECEL: begin
                if (count_r == '0) begin
                  phase_nxt = PH_STOP;
                  count_nxt = count_r - STEP_BITS'(1);
                end else begin
                  finish    = 1'b0;
                  state_nxt = S_LOAD;
                end
              end
              default: begin
                phase_nxt  = PH_IDLE;
                period_nxt = '0;
                rem_nxt    = '0;
                count_nxt  = '0;
                done_nxt   = 1'b1;
              end
            endcase
          end
        end
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          finish  = 1'b1;
          rem_nxt = REM_BITS'(div_rem);
          if (phase_r == PH_ACCEL) begin
            period_nxt = p_acc;
            if (count_r >= limit_r) begin
              if (!tri_r) begin
                phase_nxt = PH_RUN;
                limit_nxt = run_r;
                count_nxt = STEP_BITS'(1);
              end else if (run_r == '0) begin
                phase_nxt  = PH_IDLE;
                period_nxt = '0;
                rem_nxt    = '0;
                count_nxt  = '0;
                done_nxt   = 1'b1;
              end else begin
                phase_nxt = (run_less == '0) ? PH_STOP : PH_DECEL;
                count_nxt = run_less;
              end
            end
          end else begin
            period_nxt = p_dec;
            if (count_r <= STEP_BITS'(1)) begin
              phase_nxt = PH_STOP;
            end
            count_nxt = count_r - STEP_BITS'(1);
          end
        end
      end
      S_WAIT: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        ov_nxt    = 1'b1;
        op_nxt    = period_nxt;
        opos_nxt  = pos_nxt;
        oph_nxt   = phase_nxt;
        oacc_nxt  = acc_nxt;
        odone_nxt = done_nxt;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      first_r  <= PERIOD_BITS'(FIRST_PERIOD_RST);
      ramp_r   <= '0;
      min_r    <= PERIOD_BITS'(MIN_PERIOD_RST);
      max_r    <= PERIOD_BITS'(MAX_PERIOD_RST);
      period_r <= '0;
      rem_r    <= '0;
      count_r  <= '0;
      limit_r  <= '0;
      run_r    <= '0;
      decel_r  <= '0;
      phase_r  <= PH_IDLE;
      tri_r    <= 1'b0;
      up_r     <= 1'b0;
      pos_r    <= '0;
      acc_r    <= 1'b0;
      done_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      first_r  <= first_nxt;
      ramp_r   <= ramp_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      period_r <= period_nxt;
      rem_r    <= rem_nxt;
      count_r  <= count_nxt;
      limit_r  <= limit_nxt;
      run_r    <= run_nxt;
      decel_r  <= decel_nxt;
      phase_r  <= phase_nxt;
      tri_r    <= tri_nxt;
      up_r     <= up_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      done_r   <= done_nxt;
      ov_r     <= ov_nxt;
    end
    op_r    <= op_nxt;
    opos_r  <= opos_nxt;
    oph_r   <= oph_nxt;
    oacc_r  <= oacc_nxt;
    odone_r <= odone_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.step_period   = op_r;
  assign out_ch.position      = $signed(opos_r);
  assign out_ch.phase         = oph_r;
  assign out_ch.move_accepted = oacc_r;
  assign out_ch.move_done     = odone_r;

endmodule

// File: rtl/stp_checker.sv
// ----------------------------------------------------------------------------
// stp_checker: port-level checks for the stepper trapezoid ramp
// Watches the result channel and checks phase, period and flag consistency.
// ----------------------------------------------------------------------------
module stp_checker import stp_pkg::*; #(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PERIOD_BITS-1:0] step_period,
  input logic [PHASE_BITS-1:0]  phase,
  input logic                   move_accepted,
  input logic                   move_done
);

  a_accept_starts_accel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && move_accepted |-> phase == PH_ACCEL && !move_done)
    else $error("accepted move does not report the accelerating phase");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && move_done |-> phase == PH_IDLE && step_period == '0)
    else $error("finished move left motion state behind");

  a_idle_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase == PH_IDLE |-> step_period == '0)
    else $error("idle result reports a nonzero step period");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(step_period) && $stable(phase))
    else $error("stalled result item changed");

endmodule

bind stepper_trapezoid_ramp stp_checker #(
  .PERIOD_BITS(PERIOD_BITS)
) u_stp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .step_period  (out_ch.step_period),
  .phase        (out_ch.phase),
  .move_accepted(out_ch.move_accepted),
  .move_done    (out_ch.move_done)
);

// File: tb/stepper_trapezoid_ramp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_tb: self-checking bench for the step ramp planner
// Start and tick items go to the block through a valid/ready driver while a
// bit-exact model of the ramp predicts each result item. A monitor checks
// every result against the oldest prediction. A directed part covers the
// edge cases, and random moves then run under changing register settings.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_tb;
  import stp_pkg::*;

  localparam int CFG_W           = (PERIOD_BITS_DEF > STEP_BITS_DEF) ?
                                   PERIOD_BITS_DEF : STEP_BITS_DEF;
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_REPORTS     = 100;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 235;

  typedef struct {
    logic                     act;
    logic [STEP_BITS_DEF-1:0] steps;
    logic                     up;
    bit                       hold;
  } move_cmd_t;

  typedef struct packed {
    logic [PERIOD_BITS_DEF-1:0]   period;
    logic [POSITION_BITS_DEF-1:0] pos;
    logic [PHASE_BITS-1:0]        phase;
    logic                         accepted;
    logic                         done;
  } motion_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_W-1:0]        cfg_data;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();

  stepper_trapezoid_ramp i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  move_cmd_t      pending_cmds[$];
  motion_result_t predicted_reports[$];
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 14;
  int             recv_idle_pct = 58;

  logic [PERIOD_BITS_DEF-1:0]   first_per = PERIOD_BITS_DEF'(FIRST_PERIOD_RST);
  logic [STEP_BITS_DEF-1:0]     ramp_len = '0;
  logic [PERIOD_BITS_DEF-1:0]   min_per = PERIOD_BITS_DEF'(MIN_PERIOD_RST);
  logic [PERIOD_BITS_DEF-1:0]   max_per = PERIOD_BITS_DEF'(MAX_PERIOD_RST);

  logic [PERIOD_BITS_DEF-1:0]   cur_period = '0;
  logic [REM_BITS-1:0]          carry_rem = '0;
  logic [STEP_BITS_DEF-1:0]     phase_count = '0;
  logic [STEP_BITS_DEF-1:0]     phase_end = '0;
  logic [STEP_BITS_DEF-1:0]     run_steps = '0;
  logic [STEP_BITS_DEF-1:0]     decel_steps = '0;
  logic [PHASE_BITS-1:0]        cur_phase = PH_IDLE;
  logic                         is_triangle = 1'b0;
  logic                         going_up = 1'b0;
  logic [POSITION_BITS_DEF-1:0] abs_pos = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void stop_motion();
    cur_phase   = PH_IDLE;
    cur_period  = '0;
    carry_rem   = '0;
    phase_count = '0;
  endfunction

  function automatic motion_result_t plan_and_step(logic act, logic [STEP_BITS_DEF-1:0] steps,
                                                   logic up);
    motion_result_t           r;
    logic [63:0]              num;
    logic [63:0]              den;
    logic [63:0]              quo;
    logic [63:0]              nxt;
    logic [STEP_BITS_DEF-1:0] half;
    r.accepted = 1'b0;
    r.done     = 1'b0;
    half       = steps >> 1;
    if (act == ACT_START) begin
      if (steps == '0) begin
        stop_motion();
      end else if (cur_phase == PH_IDLE && ramp_len != '0) begin
        nxt = 64'(first_per);
        if (first_per <= min_per) begin
          nxt = 64'(min_per);
        end else if (first_per >= max_per) begin
          nxt = 64'(max_per);
        end
        cur_period  = nxt[PERIOD_BITS_DEF-1:0];
        carry_rem   = '0;
        phase_count = '0;
        going_up    = up;
        if (ramp_len < half) begin
          is_triangle = 1'b0;
          run_steps   = steps - (ramp_len << 1);
          decel_steps = ramp_len;
          phase_end   = ramp_len;
        end else begin
          is_triangle = 1'b1;
          phase_end   = half + STEP_BITS_DEF'(steps[0]);
          run_steps   = half;
        end
        cur_phase  = PH_ACCEL;
        r.accepted = 1'b1;
      end
    end else if (cur_phase != PH_IDLE) begin
      abs_pos = going_up ? abs_pos + POSITION_BITS_DEF'(1) : abs_pos - POSITION_BITS_DEF'(1);
      case (cur_phase)
        PH_ACCEL: begin
          phase_count = phase_count + STEP_BITS_DEF'(1);
          num = 64'({cur_period, 1'b0}) + 64'(carry_rem);
          den = 64'({phase_count, 2'b01});
          quo = num / den;
          carry_rem = REM_BITS'(num % den);
          nxt = (quo >= 64'(cur_period)) ? 64'd0 : 64'(cur_period) - quo;
          if (nxt <= 64'(min_per)) nxt = 64'(min_per);
          cur_period = nxt[PERIOD_BITS_DEF-1:0];
          if (phase_count >= phase_end) begin
            if (!is_triangle) begin
              cur_phase   = PH_RUN;
              phase_end   = run_steps;
              phase_count = STEP_BITS_DEF'(1);
            end else if (run_steps == '0) begin
              stop_motion();
              r.done = 1'b1;
            end else begin
              cur_phase   = PH_DECEL;
              phase_count = run_steps - STEP_BITS_DEF'(1);
              if (phase_count == '0) cur_phase = PH_STOP;
            end
          end
        end
        PH_RUN: begin
          phase_count = phase_count + STEP_BITS_DEF'(1);
          if (phase_count >= phase_end) begin
            cur_phase   = PH_DECEL;
            phase_count = decel_steps;
            if (phase_count == '0) cur_phase = PH_STOP;
          end
        end
        PH_DECEL: begin
          if (phase_count != '0) begin
            num = 64'({cur_period, 1'b0}) + 64'(carry_rem);
            den = 64'({phase_count, 2'b00}) - 64'd1;
            nxt = 64'(cur_period) + num / den;
            carry_rem = REM_BITS'(num % den);
            if (nxt >= 64'(max_per)) nxt = 64'(max_per);
            cur_period = nxt[PERIOD_BITS_DEF-1:0];
          end
          if (phase_count <= STEP_BITS_DEF'(1)) cur_phase = PH_STOP;
          phase_count = phase_count - STEP_BITS_DEF'(1);
        end
        default: begin
          stop_motion();
          r.done = 1'b1;
        end
      endcase
    end
    r.period = cur_period;
    r.pos    = abs_pos;
    r.phase  = cur_phase;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void queue_cmd(logic act, logic [STEP_BITS_DEF-1:0] steps, logic up,
                                    bit hold);
    move_cmd_t c;
    c.act   = act;
    c.steps = steps;
    c.up    = up;
    c.hold  = hold;
    pending_cmds.push_back(c);
  endfunction

  // Queues one start followed by its ticks, sometimes cut short by a stop,
  // with an occasional ignored start or idle tick mixed in.
  function automatic int queue_random_move();
    logic [STEP_BITS_DEF-1:0] total;
    int                       ticks;
    int                       noise_at;
    int                       i;
    bit                       cut;
    logic                     up;
    case ($urandom_range(9))
      0:       total = STEP_BITS_DEF'($urandom());
      1, 2:    total = STEP_BITS_DEF'($urandom_range(300, 41));
      default: total = STEP_BITS_DEF'($urandom_range(40, 1));
    endcase
    if (total == '0) total = STEP_BITS_DEF'(1);
    up = 1'($urandom_range(1));
    if (total > STEP_BITS_DEF'(300)) begin
      cut   = 1'b1;
      ticks = int'($urandom_range(80));
    end else begin
      cut   = ($urandom_range(9) == 0);
      ticks = cut ? int'($urandom_range(int'(total) - 1)) : int'(total);
    end
    queue_cmd(ACT_START, total, up, $urandom_range(29) == 0);
    noise_at = ($urandom_range(9) == 0) ? int'($urandom_range(ticks)) : -1;
    for (i = 0; i < ticks; i++) begin
      if (i == noise_at) begin
        queue_cmd(ACT_START, STEP_BITS_DEF'($urandom_range(24'hFFFFFF, 1)),
                  1'($urandom_range(1)), 1'b0);
      end
      queue_cmd(ACT_TICK, STEP_BITS_DEF'($urandom()), 1'($urandom_range(1)), 1'b0);
    end
    if (cut) queue_cmd(ACT_START, '0, 1'($urandom_range(1)), 1'b0);
    if ($urandom_range(7) == 0) begin
      queue_cmd(ACT_TICK, STEP_BITS_DEF'($urandom()), 1'($urandom_range(1)), 1'b0);
    end
    return 1 + ticks + int'(cut);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || predicted_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FIRST_PERIOD: first_per = val[PERIOD_BITS_DEF-1:0];
      CFG_RAMP_STEPS:   ramp_len  = val[STEP_BITS_DEF-1:0];
      CFG_MIN_PERIOD:   min_per   = val[PERIOD_BITS_DEF-1:0];
      default:          max_per   = val[PERIOD_BITS_DEF-1:0];
    endcase
  endtask

  // The upper data bits of the 16-bit registers carry random filler.
  task automatic configure(logic [15:0] first, logic [23:0] ramp, logic [15:0] lo_per,
                           logic [15:0] hi_per);
    wait_idle();
    write_reg(CFG_FIRST_PERIOD, {8'($urandom()), first});
    write_reg(CFG_RAMP_STEPS, ramp);
    write_reg(CFG_MIN_PERIOD, {8'($urandom()), lo_per});
    write_reg(CFG_MAX_PERIOD, {8'($urandom()), hi_per});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= ACT_START;
      in_ch.move_steps <= '0;
      in_ch.count_up   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_reports.push_back(plan_and_step(in_ch.action, in_ch.move_steps,
                                                  in_ch.count_up));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].hold && predicted_reports.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid      <= 1'b1;
          in_ch.action     <= pending_cmds[0].act;
          in_ch.move_steps <= pending_cmds[0].steps;
          in_ch.count_up   <= pending_cmds[0].up;
          void'(pending_cmds.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    motion_result_t seen;
    motion_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.step_period, out_ch.position, out_ch.phase, out_ch.move_accepted,
                out_ch.move_done};
        if (predicted_reports.size() == 0) begin
          report_mismatch("result item with no prediction waiting");
        end else begin
          want = predicted_reports.pop_front();
          if (seen !== want) begin
            report_mismatch($sformatf(
              "period %0d/%0d pos %0d/%0d phase %0d/%0d acc %b/%b done %b/%b (got/exp)",
              seen.period, want.period, $signed(seen.pos), $signed(want.pos),
              seen.phase, want.phase, seen.accepted, want.accepted,
              seen.done, want.done));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stepper_trapezoid_ramp_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [15:0] first_v;
    logic [23:0] ramp_v;
    logic [15:0] lo_v;
    logic [15:0] hi_v;
    int          produced;
    int          ph;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_FIRST_PERIOD;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // With no ramp length every start is refused, and idle ticks do nothing.
    configure(16'(FIRST_PERIOD_RST), 24'd0, 16'(MIN_PERIOD_RST), 16'(MAX_PERIOD_RST));
    queue_cmd(ACT_TICK, 24'hFFFFFF, 1'b1, 1'b0);
    queue_cmd(ACT_START, 24'd10, 1'b1, 1'b0);
    queue_cmd(ACT_START, 24'd0, 1'b0, 1'b0);

    // The first period is clamped to the maximum. Single-step, short triangle
    // and trapezoid moves follow, with a start while moving and a stop.
    configure(16'hFFFF, 24'd2, 16'(MIN_PERIOD_RST), 16'(MAX_PERIOD_RST));
    queue_cmd(ACT_START, 24'd1, 1'b0, 1'b0);
    queue_cmd(ACT_TICK, 24'd0, 1'b0, 1'b0);
    queue_cmd(ACT_START, 24'd3, 1'b1, 1'b1);
    repeat (3) queue_cmd(ACT_TICK, 24'd0, 1'b0, 1'b0);
    queue_cmd(ACT_START, 24'd7, 1'b1, 1'b0);
    queue_cmd(ACT_TICK, 24'd0, 1'b1, 1'b0);
    queue_cmd(ACT_START, 24'd5, 1'b0, 1'b0);
    repeat (6) queue_cmd(ACT_TICK, 24'hFFFFFF, 1'b0, 1'b0);
    queue_cmd(ACT_START, 24'hFFFFFF, 1'b0, 1'b0);
    repeat (2) queue_cmd(ACT_TICK, 24'd0, 1'b1, 1'b0);
    queue_cmd(ACT_START, 24'd0, 1'b1, 1'b0);

    // A zero minimum lets the acceleration divide swallow the whole period.
    configure(16'd0, 24'hFFFFFF, 16'd0, 16'hFFFF);
    queue_cmd(ACT_START, 24'h800001, 1'b0, 1'b0);
    repeat (2) queue_cmd(ACT_TICK, 24'd0, 1'b0, 1'b0);
    queue_cmd(ACT_START, 24'd0, 1'b0, 1'b0);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(7))
        0:       first_v = 16'd0;
        1:       first_v = 16'hFFFF;
        default: first_v = 16'($urandom_range(65535, 200));
      endcase
      case ($urandom_range(7))
        0:       ramp_v = 24'hFFFFFF;
        default: ramp_v = 24'($urandom_range(30, 1));
      endcase
      case ($urandom_range(7))
        0:       lo_v = 16'd0;
        default: lo_v = 16'($urandom_range(400, 1));
      endcase
      case ($urandom_range(7))
        0:       hi_v = 16'hFFFF;
        default: hi_v = 16'($urandom_range(65535, 500));
      endcase
      if (ph == 2) lo_v = 16'hFFFF;
      if (ph == 4) hi_v = 16'd1;
      configure(first_v, ramp_v, lo_v, hi_v);
      if (ph < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 58;
      end else if (ph < 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      produced = 0;
      while (produced < ITEMS_PER_PHASE) produced += queue_random_move();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("stepper_trapezoid_ramp_tb OK");
    end else begin
      $display("stepper_trapezoid_ramp_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/stp_pkg.sv
rtl/stp_if.sv
rtl/stp_div.sv
rtl/stepper_trapezoid_ramp.sv
rtl/stp_checker.sv
tb/stepper_trapezoid_ramp_tb.sv
